FILE: hw/rtl/ipp_pkg.sv
`default_nettype none

package ipp_pkg;

	// result status codes
	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_MALFORMED   = 2'd1;
	localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

	// address family codes
	localparam logic [1:0] FAM_V4    = 2'd0;
	localparam logic [1:0] FAM_OTHER = 2'd2;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [15:0] OCTET_MAX  = 16'd255;
	localparam logic [3:0]  DIGIT_MAX  = 4'd9;
	localparam logic [2:0]  GROUP_LAST = 3'd7;
	localparam logic [2:0]  GROUP_TAIL = 3'd6;
	localparam logic [2:0]  HEX_DIGITS = 3'd4;
	localparam logic [2:0]  DEC_DIGITS = 3'd3;

	typedef enum logic [7:0] {
		PH_START  = 8'b0000_0001,
		PH_V4     = 8'b0000_0010,
		PH_COLON1 = 8'b0000_0100,
		PH_ITEM   = 8'b0000_1000,
		PH_GAP    = 8'b0001_0000,
		PH_HEX    = 8'b0010_0000,
		PH_TAIL   = 8'b0100_0000,
		PH_ENDED  = 8'b1000_0000
	} phase_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REREAD = 5'b00010,
		ST_END    = 5'b00100,
		ST_EXPAND = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	function automatic logic is_dec(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic hex_ok(logic [7:0] c);
		logic [7:0] l;
		l = c | CASE_BIT;
		return is_dec(c) || ((l >= CH_LA) && (l <= CH_LF));
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [7:0] l;
		l = c | CASE_BIT;
		if (is_dec(c)) begin
			return c[3:0];
		end
		return 4'(l[3:0] + 4'd9);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ip_address_text_parser.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   tvalid / tready    tdata: character, tuser: family, tlast: last
// m_*       out  tvalid / tready    tdata: address_high, address_low; tuser: status
//
// Characters are taken only in ST_IDLE; a zero terminator after the first character runs the end check.
// A '.' that turns a hex group into the first octet of a dotted tail
// re-reads its digits in ST_REREAD through the shared multiply-add unit (x10 + d).
// The last character is followed by the end check (ST_END), the group moves of a
// "::" expansion (ST_EXPAND) and the load of the result register (ST_DONE).
// Reset clears all parse state at once; the block is ready right after it.
// A pending result waits in the output register while the next text streams in;
// only its own result load stalls until the output register is free.

module ip_address_text_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // [7:0] character
	input  wire logic [1:0]   s_tuser,  // [1:0] family
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,  // [63:0] address_high, [127:64] address_low
	output logic [1:0]        m_tuser   // [1:0] status
);

	ipp_pkg::state_t st_q;
	ipp_pkg::phase_t ph_q;
	logic            err_q;
	logic [15:0]     grp_q [8];
	logic [2:0]      gcnt_q;
	logic            gap_none_q;
	logic [2:0]      gap_q;
	logic [15:0]     dval_q;
	logic [2:0]      dcnt_q;
	logic            lz_q;
	logic [7:0]      oct_q [4];
	logic [1:0]      ocnt_q;
	logic            last_q;
	logic            tail_q;
	logic [15:0]     acc_q;
	logic [2:0]      kcnt_q;

	logic            out_valid_q;
	logic [127:0]    out_data_q;
	logic [1:0]      out_status_q;

	logic            accept;
	logic            out_free;
	logic [7:0]      c;
	logic            c_dec;
	logic            c_hex;
	logic [3:0]      c_hval;
	logic            close_ok;
	logic [1:0]      nib_sel;
	logic [1:0]      top_sel;
	logic [3:0]      nib;
	logic            lz_new;
	logic [15:0]     mac_a;
	logic [3:0]      mac_d;
	logic [15:0]     mac_y;
	logic [3:0]      gap_end;
	logic [2:0]      src;
	logic [2:0]      gnext;
	ipp_pkg::state_t after_st;

	assign s_tready = (st_q == ipp_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	assign c      = s_tdata;
	assign c_dec  = ipp_pkg::is_dec(c);
	assign c_hex  = ipp_pkg::hex_ok(c);
	assign c_hval = ipp_pkg::hex_val(c);

	assign close_ok = (dcnt_q != 3'd0) && !((dcnt_q > 3'd1) && lz_q)
		&& (dval_q <= ipp_pkg::OCTET_MAX);

	// hex digits of the group being re-read as decimal, most significant first
	assign nib_sel = 2'(kcnt_q - 3'd1);
	assign top_sel = 2'(dcnt_q - 3'd1);
	assign nib     = dval_q[{nib_sel, 2'b00} +: 4];
	assign lz_new  = (dval_q[{top_sel, 2'b00} +: 4] == 4'd0);

	// shared multiply-add unit: decimal digit accumulation
	assign mac_a = (st_q == ipp_pkg::ST_REREAD) ? acc_q : dval_q;
	assign mac_d = (st_q == ipp_pkg::ST_REREAD) ? nib : c[3:0];
	assign mac_y = 16'(mac_a * 16'd10 + {12'd0, mac_d});

	// gap expansion: slots from gap up to gap_end read zero, later slots shift right
	assign gap_end  = {1'b0, gap_q} + (4'd7 - {1'b0, gcnt_q});
	assign src      = 3'(kcnt_q + gcnt_q + 3'd1);
	assign gnext    = 3'(gcnt_q + 3'd1);
	assign after_st = last_q ? ipp_pkg::ST_DONE : ipp_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ipp_pkg::ST_IDLE;
			ph_q       <= ipp_pkg::PH_START;
			err_q      <= 1'b0;
			grp_q      <= '{default: '0};
			gcnt_q     <= '0;
			gap_none_q <= 1'b1;
			gap_q      <= '0;
			dval_q     <= '0;
			dcnt_q     <= '0;
			lz_q       <= 1'b0;
			oct_q      <= '{default: '0};
			ocnt_q     <= '0;
			last_q     <= 1'b0;
			tail_q     <= 1'b0;
			acc_q      <= '0;
			kcnt_q     <= '0;
		end else begin
			unique case (st_q)
				ipp_pkg::ST_IDLE: begin
					if (accept) begin
						last_q <= s_tlast;
						st_q   <= s_tlast ? ipp_pkg::ST_END : ipp_pkg::ST_IDLE;
						if (!err_q) begin
							if (ph_q == ipp_pkg::PH_START) begin
								priority if (s_tuser >= ipp_pkg::FAM_OTHER) begin
									err_q <= 1'b1;
								end else if (c == ipp_pkg::CH_NUL) begin
									err_q <= 1'b1;
									ph_q  <= ipp_pkg::PH_ENDED;
								end else if (s_tuser == ipp_pkg::FAM_V4) begin
									if (c_dec) begin
										ph_q   <= ipp_pkg::PH_V4;
										lz_q   <= (c == ipp_pkg::CH_ZERO);
										dval_q <= mac_y;
										dcnt_q <= 3'd1;
									end else begin
										err_q <= 1'b1;
										ph_q  <= ipp_pkg::PH_ENDED;
									end
								end else if (c == ipp_pkg::CH_COLON) begin
									ph_q <= ipp_pkg::PH_COLON1;
								end else if (c_hex) begin
									ph_q   <= ipp_pkg::PH_HEX;
									dval_q <= {12'd0, c_hval};
									dcnt_q <= 3'd1;
								end else begin
									err_q <= 1'b1;
									ph_q  <= ipp_pkg::PH_ENDED;
								end
							end else if (ph_q != ipp_pkg::PH_ENDED) begin
								if (c == ipp_pkg::CH_NUL) begin
									// terminator: run the end check now
									st_q <= ipp_pkg::ST_END;
								end else begin
									unique case (ph_q)
										ipp_pkg::PH_V4, ipp_pkg::PH_TAIL: begin
											priority if (c_dec && (dcnt_q < ipp_pkg::DEC_DIGITS)) begin
												if (dcnt_q == 3'd0) begin
													lz_q <= (c == ipp_pkg::CH_ZERO);
												end
												dval_q <= mac_y;
												dcnt_q <= 3'(dcnt_q + 3'd1);
											end else if (!close_ok || (ocnt_q == 2'd3)
												|| (c != ipp_pkg::CH_DOT)) begin
												err_q <= 1'b1;
												ph_q  <= ipp_pkg::PH_ENDED;
											end else begin
												oct_q[ocnt_q] <= dval_q[7:0];
												ocnt_q        <= 2'(ocnt_q + 2'd1);
												dval_q        <= '0;
												dcnt_q        <= '0;
												lz_q          <= 1'b0;
											end
										end
										ipp_pkg::PH_COLON1: begin
											if (c == ipp_pkg::CH_COLON) begin
												ph_q          <= ipp_pkg::PH_GAP;
												gap_none_q    <= 1'b0;
												gap_q         <= gcnt_q;
												grp_q[gcnt_q] <= '0;
											end else begin
												err_q <= 1'b1;
												ph_q  <= ipp_pkg::PH_ENDED;
											end
										end
										ipp_pkg::PH_ITEM: begin
											priority if ((c == ipp_pkg::CH_COLON) && gap_none_q) begin
												ph_q          <= ipp_pkg::PH_GAP;
												gap_none_q    <= 1'b0;
												gap_q         <= gcnt_q;
												grp_q[gcnt_q] <= '0;
											end else if (c_hex) begin
												ph_q   <= ipp_pkg::PH_HEX;
												dval_q <= {12'd0, c_hval};
												dcnt_q <= 3'd1;
											end else begin
												err_q <= 1'b1;
												ph_q  <= ipp_pkg::PH_ENDED;
											end
										end
										ipp_pkg::PH_GAP: begin
											if ((gcnt_q != ipp_pkg::GROUP_LAST) && c_hex) begin
												gcnt_q <= gnext;
												ph_q   <= ipp_pkg::PH_HEX;
												dval_q <= {12'd0, c_hval};
												dcnt_q <= 3'd1;
											end else begin
												err_q <= 1'b1;
												ph_q  <= ipp_pkg::PH_ENDED;
											end
										end
										ipp_pkg::PH_HEX: begin
											if (c_hex && (dcnt_q < ipp_pkg::HEX_DIGITS)) begin
												dval_q <= {dval_q[11:0], c_hval};
												dcnt_q <= 3'(dcnt_q + 3'd1);
											end else begin
												grp_q[gcnt_q] <= dval_q;
												priority if (gcnt_q == ipp_pkg::GROUP_LAST) begin
													err_q <= 1'b1;
													ph_q  <= ipp_pkg::PH_ENDED;
												end else if (c == ipp_pkg::CH_COLON) begin
													gcnt_q <= gnext;
													ph_q   <= ipp_pkg::PH_ITEM;
												end else if ((c != ipp_pkg::CH_DOT)
													|| ((gcnt_q < ipp_pkg::GROUP_TAIL) && gap_none_q)
													|| (dcnt_q > ipp_pkg::DEC_DIGITS)) begin
													err_q <= 1'b1;
													ph_q  <= ipp_pkg::PH_ENDED;
												end else begin
													// re-read the group as the first decimal octet
													acc_q  <= '0;
													kcnt_q <= dcnt_q;
													st_q   <= ipp_pkg::ST_REREAD;
												end
											end
										end
										default: ;
									endcase
								end
							end
						end
					end
				end
				ipp_pkg::ST_REREAD: begin
					if (nib > ipp_pkg::DIGIT_MAX) begin
						err_q <= 1'b1;
						ph_q  <= ipp_pkg::PH_ENDED;
						st_q  <= last_q ? ipp_pkg::ST_END : ipp_pkg::ST_IDLE;
					end else begin
						acc_q  <= mac_y;
						kcnt_q <= 3'(kcnt_q - 3'd1);
						if (kcnt_q == 3'd1) begin
							gcnt_q       <= gnext;
							grp_q[gnext] <= '0;
							ph_q         <= ipp_pkg::PH_TAIL;
							st_q         <= last_q ? ipp_pkg::ST_END : ipp_pkg::ST_IDLE;
							if (((dcnt_q > 3'd1) && lz_new) || (mac_y > ipp_pkg::OCTET_MAX)) begin
								err_q <= 1'b1;
								ph_q  <= ipp_pkg::PH_ENDED;
							end else begin
								oct_q[0] <= mac_y[7:0];
								ocnt_q   <= 2'd1;
								dval_q   <= '0;
								dcnt_q   <= '0;
								lz_q     <= 1'b0;
							end
						end
					end
				end
				ipp_pkg::ST_END: begin
					st_q <= after_st;
					if (!err_q && (ph_q != ipp_pkg::PH_ENDED)) begin
						ph_q <= ipp_pkg::PH_ENDED;
						unique case (ph_q)
							ipp_pkg::PH_V4: begin
								if (close_ok && (ocnt_q == 2'd3)) begin
									oct_q[3] <= dval_q[7:0];
									grp_q[6] <= {oct_q[0], oct_q[1]};
									grp_q[7] <= {oct_q[2], dval_q[7:0]};
								end else begin
									err_q <= 1'b1;
								end
							end
							ipp_pkg::PH_GAP: begin
								tail_q <= 1'b0;
								kcnt_q <= ipp_pkg::GROUP_LAST;
								st_q   <= ipp_pkg::ST_EXPAND;
							end
							ipp_pkg::PH_HEX: begin
								grp_q[gcnt_q] <= dval_q;
								priority if (!gap_none_q) begin
									tail_q <= 1'b0;
									kcnt_q <= ipp_pkg::GROUP_LAST;
									st_q   <= ipp_pkg::ST_EXPAND;
								end else if (gcnt_q != ipp_pkg::GROUP_LAST) begin
									err_q <= 1'b1;
								end else begin
								end
							end
							ipp_pkg::PH_TAIL: begin
								if (close_ok && (ocnt_q == 2'd3)) begin
									oct_q[3] <= dval_q[7:0];
									if (gap_none_q) begin
										grp_q[6] <= {oct_q[0], oct_q[1]};
										grp_q[7] <= {oct_q[2], dval_q[7:0]};
									end else begin
										tail_q <= 1'b1;
										kcnt_q <= ipp_pkg::GROUP_LAST;
										st_q   <= ipp_pkg::ST_EXPAND;
									end
								end else begin
									err_q <= 1'b1;
								end
							end
							default: begin
								err_q <= 1'b1;
							end
						endcase
					end
				end
				ipp_pkg::ST_EXPAND: begin
					// walk slots downward so each source is read before it is overwritten
					priority if ({1'b0, kcnt_q} < {1'b0, gap_q}) begin
					end else if ({1'b0, kcnt_q} < gap_end) begin
						grp_q[kcnt_q] <= '0;
					end else begin
						grp_q[kcnt_q] <= grp_q[src];
					end
					if (kcnt_q == 3'd0) begin
						if (tail_q) begin
							grp_q[6] <= {oct_q[0], oct_q[1]};
							grp_q[7] <= {oct_q[2], oct_q[3]};
						end
						st_q <= after_st;
					end else begin
						kcnt_q <= 3'(kcnt_q - 3'd1);
					end
				end
				ipp_pkg::ST_DONE: begin
					if (out_free) begin
						// result taken into the output register: start a fresh string
						st_q       <= ipp_pkg::ST_IDLE;
						ph_q       <= ipp_pkg::PH_START;
						err_q      <= 1'b0;
						grp_q      <= '{default: '0};
						gcnt_q     <= '0;
						gap_none_q <= 1'b1;
						gap_q      <= '0;
						dval_q     <= '0;
						dcnt_q     <= '0;
						lz_q       <= 1'b0;
						oct_q      <= '{default: '0};
						ocnt_q     <= '0;
						last_q     <= 1'b0;
						tail_q     <= 1'b0;
					end
				end
				default: begin
					st_q <= ipp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == ipp_pkg::ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ipp_pkg::ST_DONE) && out_free) begin
			if (err_q) begin
				out_status_q <= (ph_q == ipp_pkg::PH_START) ? ipp_pkg::STATUS_UNSUPPORTED
					: ipp_pkg::STATUS_MALFORMED;
				out_data_q   <= '0;
			end else begin
				out_status_q <= ipp_pkg::STATUS_OK;
				out_data_q   <= {grp_q[4], grp_q[5], grp_q[6], grp_q[7],
					grp_q[0], grp_q[1], grp_q[2], grp_q[3]};
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ipp_check.sv
`default_nettype none

module ipp_check (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         s_tlast,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata,
	input wire logic [1:0]   m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ipp_pkg::STATUS_OK) || (m_tuser == ipp_pkg::STATUS_MALFORMED)
			|| (m_tuser == ipp_pkg::STATUS_UNSUPPORTED))
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ipp_pkg::STATUS_OK) |-> (m_tdata == '0))
		else $error("failed parse carries a nonzero address");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("ready right after the last character");

endmodule

bind ip_address_text_parser ipp_check u_ipp_check (.*);

`default_nettype wire
